/* rtl/rbt_pkg.sv */
// Shared types and constants for the ranging beacon table.
package rbt_pkg;

    localparam int IN_TDATA_W  = 360;
    localparam int OUT_TDATA_W = 304;
    localparam int OUT_TUSER_W = 3;
    localparam int MAX_RESULTS = 8;
    localparam int FOUND_W     = 4;

    localparam logic [31:0] ONE_SECOND_US = 32'd1000000;

    localparam logic [2:0] STAT_UPDATED  = 3'd0;
    localparam logic [2:0] STAT_FILLED   = 3'd1;
    localparam logic [2:0] STAT_REPLACED = 3'd2;
    localparam logic [2:0] STAT_FRESH    = 3'd3;
    localparam logic [2:0] STAT_NONE     = 3'd4;

    localparam logic CMD_STORE = 1'b0;
    localparam logic CMD_SCAN  = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EVAL,
        S_WRITE,
        S_FINISH
    } t_state;

    typedef enum logic {
        CMP_LESS,
        CMP_AGE
    } t_cmp_op;

    typedef struct packed {
        logic wr;
        logic rd;
    } t_mem_ctl;

    typedef struct packed {
        logic [7:0]  id;
        logic [63:0] lat;
        logic [63:0] lon;
        logic [31:0] alt;
        logic [31:0] rng;
        logic [31:0] acc;
        logic [63:0] stime;
    } t_entry;

    typedef struct packed {
        logic        cmd;
        t_entry      ent;
        logic [63:0] ctime;
    } t_item;

endpackage

/* rtl/rbt_entry_mem.sv */
// Entry storage: one write port, one registered read port.
module rbt_entry_mem #(
    parameter int ENTRIES = 8,
    parameter int IW      = 3
) (
    input  logic              i_clk,
    input  rbt_pkg::t_mem_ctl i_ctl,
    input  logic [IW-1:0]     i_waddr,
    input  logic [IW-1:0]     i_raddr,
    input  rbt_pkg::t_entry   i_wdata,
    output rbt_pkg::t_entry   o_rdata
);
    import rbt_pkg::*;

    t_entry r_mem [ENTRIES];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/rbt_cmp_unit.sv */
// Shared 64-bit subtractor: oldest-time compare or age-window check.
module rbt_cmp_unit (
    input  rbt_pkg::t_cmp_op i_op,
    input  logic [63:0]      i_a,
    input  logic [63:0]      i_b,
    input  logic [31:0]      i_max_age,
    output logic             o_hit
);
    import rbt_pkg::*;

    logic [64:0] diff;

    assign diff = {1'b0, i_a} - {1'b0, i_b};

    always_comb begin
        case (i_op)
            CMP_LESS: o_hit = diff[64];
            CMP_AGE:  o_hit = (diff[63:32] == 32'd0) && (diff[31:0] <= i_max_age);
            default:  o_hit = 1'b0;
        endcase
    end

endmodule

/* rtl/rbt_ctrl.sv */
// Sequencer: sweeps the entries for store and scan, owns valid bits and result register.
module rbt_ctrl #(
    parameter int ENTRIES = 8,
    parameter int IW      = 3
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  rbt_pkg::t_item    i_item,
    output rbt_pkg::t_mem_ctl o_mem_ctl,
    output logic [IW-1:0]     o_raddr,
    output logic [IW-1:0]     o_waddr,
    output rbt_pkg::t_entry   o_wdata,
    input  rbt_pkg::t_entry   i_rdata,
    output rbt_pkg::t_cmp_op  o_cmp_op,
    output logic [63:0]       o_cmp_a,
    output logic [63:0]       o_cmp_b,
    input  logic              i_cmp_hit,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [2:0]        o_status,
    output logic [2:0]        o_slot,
    output rbt_pkg::t_entry   o_ent,
    output logic              o_last
);
    import rbt_pkg::*;

    localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

    t_state               r_state;
    t_state               n_state;
    t_item                r_item;
    logic [IW-1:0]        r_idx;
    logic [ENTRIES-1:0]   r_valid;
    logic                 r_match_hit;
    logic [IW-1:0]        r_match_idx;
    logic                 r_free_hit;
    logic [IW-1:0]        r_free_idx;
    logic [IW-1:0]        r_old_idx;
    logic [63:0]          r_old_time;
    logic                 r_pend_vld;
    logic [IW-1:0]        r_pend_idx;
    t_entry               r_pend_ent;
    logic [FOUND_W-1:0]   r_found;
    logic                 r_out_vld;
    logic [2:0]           r_out_status;
    logic [2:0]           r_out_slot;
    t_entry               r_out_ent;
    logic                 r_out_last;

    logic                 out_free;
    logic                 cur_valid;
    logic                 fresh;
    logic                 stall;
    logic                 sweep_end;
    logic [IW-1:0]        wr_slot;
    logic [2:0]           wr_status;
    logic                 take;
    logic                 eval_go;
    logic                 wr_go;
    logic                 fin_go;
    logic                 push_pend;

    assign out_free  = !r_out_vld || i_out_ready;
    assign cur_valid = r_valid[r_idx];
    assign fresh     = (r_item.cmd == CMD_SCAN) && cur_valid && i_cmp_hit;
    // a new fresh entry can only be parked once the previous one has left
    assign stall     = (r_state == S_EVAL) && fresh && r_pend_vld && !out_free;
    assign sweep_end = (r_idx == LAST_IDX) ||
                       (fresh && (r_found == FOUND_W'(MAX_RESULTS - 1)));

    always_comb begin
        if (r_match_hit) begin
            wr_slot   = r_match_idx;
            wr_status = STAT_UPDATED;
        end else if (r_free_hit) begin
            wr_slot   = r_free_idx;
            wr_status = STAT_FILLED;
        end else begin
            wr_slot   = r_old_idx;
            wr_status = STAT_REPLACED;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_READ;
            end
            S_READ: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                if (!stall) begin
                    if (!sweep_end) n_state = S_READ;
                    else if (r_item.cmd == CMD_SCAN) n_state = S_FINISH;
                    else n_state = S_WRITE;
                end
            end
            S_WRITE, S_FINISH: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_ready   = (r_state == S_IDLE);
        o_mem_ctl.rd = (r_state == S_READ);
        o_mem_ctl.wr = (r_state == S_WRITE) && out_free;
        take         = (r_state == S_IDLE) && i_in_valid;
        eval_go      = (r_state == S_EVAL) && !stall;
        wr_go        = o_mem_ctl.wr;
        fin_go       = (r_state == S_FINISH) && out_free;
        push_pend    = eval_go && fresh && r_pend_vld;
    end

    assign o_raddr  = r_idx;
    assign o_waddr  = wr_slot;
    assign o_wdata  = r_item.ent;
    assign o_cmp_op = (r_item.cmd == CMD_SCAN) ? CMP_AGE : CMP_LESS;
    assign o_cmp_a  = (r_item.cmd == CMD_SCAN) ? r_item.ctime : i_rdata.stime;
    assign o_cmp_b  = (r_item.cmd == CMD_SCAN) ? i_rdata.stime : r_old_time;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_valid     <= '0;
            r_match_hit <= 1'b0;
            r_free_hit  <= 1'b0;
            r_pend_vld  <= 1'b0;
            r_found     <= '0;
            r_out_vld   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (take) begin
                r_idx       <= '0;
                r_match_hit <= 1'b0;
                r_free_hit  <= 1'b0;
                r_pend_vld  <= 1'b0;
                r_found     <= '0;
            end else if (eval_go) begin
                if (!sweep_end) r_idx <= r_idx + 1'b1;
                if (r_item.cmd == CMD_STORE) begin
                    if (cur_valid && (i_rdata.id == r_item.ent.id) && !r_match_hit) begin
                        r_match_hit <= 1'b1;
                    end
                    if (!cur_valid && !r_free_hit) begin
                        r_free_hit <= 1'b1;
                    end
                end else if (fresh) begin
                    r_pend_vld <= 1'b1;
                    r_found    <= r_found + 1'b1;
                end
            end
            if (wr_go) begin
                r_valid[wr_slot] <= 1'b1;
            end
            if (wr_go || fin_go || push_pend) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item <= i_item;
        end
        if (eval_go) begin
            if (r_item.cmd == CMD_STORE) begin
                if (cur_valid && (i_rdata.id == r_item.ent.id) && !r_match_hit) begin
                    r_match_idx <= r_idx;
                end
                if (!cur_valid && !r_free_hit) begin
                    r_free_idx <= r_idx;
                end
                // strict less keeps the lowest index on ties
                if ((r_idx == '0) || i_cmp_hit) begin
                    r_old_idx  <= r_idx;
                    r_old_time <= i_rdata.stime;
                end
            end else if (fresh) begin
                r_pend_idx <= r_idx;
                r_pend_ent <= i_rdata;
            end
        end
        if (wr_go) begin
            r_out_status <= wr_status;
            r_out_slot   <= 3'(wr_slot);
            r_out_ent    <= '0;
            r_out_last   <= 1'b1;
        end else if (fin_go) begin
            r_out_last <= 1'b1;
            if (r_pend_vld) begin
                r_out_status <= STAT_FRESH;
                r_out_slot   <= 3'(r_pend_idx);
                r_out_ent    <= r_pend_ent;
            end else begin
                r_out_status <= STAT_NONE;
                r_out_slot   <= 3'd0;
                r_out_ent    <= '0;
            end
        end else if (push_pend) begin
            r_out_status <= STAT_FRESH;
            r_out_slot   <= 3'(r_pend_idx);
            r_out_ent    <= r_pend_ent;
            r_out_last   <= 1'b0;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_status    = r_out_status;
    assign o_slot      = r_out_slot;
    assign o_ent       = r_out_ent;
    assign o_last      = r_out_last;

endmodule

/* rtl/ranging_beacon_table.sv */
// Top level of the ranging beacon table: stream ports, max_age register, unit wiring.
//
// Input stream s_axis: tuser carries the command (store or scan); tdata carries the
// report and the present time. A store beat writes one report into the table and
// yields one result beat; a scan beat yields one beat per fresh entry in index
// order (at most eight), or a single "none fresh" beat, with tlast on the final one.
// The cfg channel writes max_age and is always ready; write it only while idle.
// Each item sweeps the entries (a scan stops once it has found eight) through the single
// read port of the entry memory and the shared 64-bit subtractor, a read state and an
// evaluate state per entry: a store or a scan holds tready low through the sweep and its
// write or finish state, plus any time spent waiting on the result register.
// Results leave from a register, so the next item is taken while the last result
// still waits on m_axis.
// A fresh entry waits in a holding register until the sweep proves whether it is
// the last; if another fresh entry turns up while m_axis stalls, the sweep stops until the result register drains.
// Reset clears every valid bit and the result valid flag, and sets max_age to one second.
module ranging_beacon_table #(
    parameter int ENTRIES = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // id, latitude, longitude, altitude, range, accuracy, sample_time, current_time
    input  logic [rbt_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // command
    input  logic [0:0]                       s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // slot, id, latitude, longitude, altitude, range, accuracy, sample_time, zero pad
    output logic [rbt_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // status
    output logic [rbt_pkg::OUT_TUSER_W-1:0]  m_axis_tuser,
    output logic                             m_axis_tlast,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [31:0]                      i_cfg_data
);
    import rbt_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    logic [31:0]   r_max_age;
    t_item         in_item;
    t_mem_ctl      mem_ctl;
    logic [IW-1:0] mem_raddr;
    logic [IW-1:0] mem_waddr;
    t_entry        mem_wdata;
    t_entry        mem_rdata;
    t_cmp_op       cmp_op;
    logic [63:0]   cmp_a;
    logic [63:0]   cmp_b;
    logic          cmp_hit;
    logic [2:0]    out_status;
    logic [2:0]    out_slot;
    t_entry        out_ent;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_age <= ONE_SECOND_US;
        end else if (i_cfg_valid) begin
            r_max_age <= i_cfg_data;
        end
    end

    assign in_item.cmd       = s_axis_tuser[0];
    assign in_item.ent.id    = s_axis_tdata[7:0];
    assign in_item.ent.lat   = s_axis_tdata[71:8];
    assign in_item.ent.lon   = s_axis_tdata[135:72];
    assign in_item.ent.alt   = s_axis_tdata[167:136];
    assign in_item.ent.rng   = s_axis_tdata[199:168];
    assign in_item.ent.acc   = s_axis_tdata[231:200];
    assign in_item.ent.stime = s_axis_tdata[295:232];
    assign in_item.ctime     = s_axis_tdata[359:296];

    rbt_ctrl #(
        .ENTRIES (ENTRIES),
        .IW      (IW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_item      (in_item),
        .o_mem_ctl   (mem_ctl),
        .o_raddr     (mem_raddr),
        .o_waddr     (mem_waddr),
        .o_wdata     (mem_wdata),
        .i_rdata     (mem_rdata),
        .o_cmp_op    (cmp_op),
        .o_cmp_a     (cmp_a),
        .o_cmp_b     (cmp_b),
        .i_cmp_hit   (cmp_hit),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_status    (out_status),
        .o_slot      (out_slot),
        .o_ent       (out_ent),
        .o_last      (m_axis_tlast)
    );

    rbt_entry_mem #(
        .ENTRIES (ENTRIES),
        .IW      (IW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_ctl   (mem_ctl),
        .i_waddr (mem_waddr),
        .i_raddr (mem_raddr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    rbt_cmp_unit u_cmp (
        .i_op      (cmp_op),
        .i_a       (cmp_a),
        .i_b       (cmp_b),
        .i_max_age (r_max_age),
        .o_hit     (cmp_hit)
    );

    assign m_axis_tuser = out_status;
    assign m_axis_tdata = {5'd0, out_ent.stime, out_ent.acc, out_ent.rng, out_ent.alt,
                           out_ent.lon, out_ent.lat, out_ent.id, out_slot};

endmodule

/* rtl/rbt_checker.sv */
// Port-level checks for the ranging beacon table, bound to the top level.
module rbt_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [rbt_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input logic [rbt_pkg::OUT_TUSER_W-1:0]  m_axis_tuser,
    input logic                             m_axis_tlast
);
    import rbt_pkg::*;

    // one item at a time: the table is busy right after taking a beat
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while a previous item is still in work");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result beat changed");

    // store results and the empty-scan result always close their item
    a_single_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != STAT_FRESH) |-> m_axis_tlast)
        else $error("single result beat without tlast");

    a_none_is_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == STAT_NONE) |-> (m_axis_tdata == '0))
        else $error("none-fresh beat carries entry data");

endmodule

bind ranging_beacon_table rbt_checker u_rbt_checker (.*);
